// ----- design/tcprf_pkg.sv -----
// Package: shared types, codes and constants of the TCP receive frame filter.
`default_nettype none

package tcprf_pkg;

  // Default frame length limit; bytes beyond it are dropped
  localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

  // Depth of the result queue in front of the output channel
  localparam int unsigned RES_DEPTH = 4;

  // Header field constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  VERSION_MASK   = 8'hF0;
  localparam logic [7:0]  VERSION_IPV4   = 8'h40;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam logic [7:0]  FLAG_RST       = 8'h04;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
  localparam int unsigned MIN_FRAME      = 54;

  // Fixed byte positions in the frame
  localparam int unsigned POS_TYPE_HI  = 12;
  localparam int unsigned POS_TYPE_LO  = 13;
  localparam int unsigned POS_VER_IHL  = 14;
  localparam int unsigned POS_TOT_HI   = 16;
  localparam int unsigned POS_TOT_LO   = 17;
  localparam int unsigned POS_PROTO    = 23;
  localparam int unsigned POS_SRC_0    = 26;
  localparam int unsigned POS_SRC_3    = 29;
  localparam int unsigned POS_IP_START = 14;
  localparam int unsigned POS_TCP_MIN  = 34;

  // Byte offsets within the TCP header
  localparam int unsigned OFS_DPORT_HI = 2;
  localparam int unsigned OFS_DPORT_LO = 3;
  localparam int unsigned OFS_SEQ_0    = 4;
  localparam int unsigned OFS_SEQ_3    = 7;
  localparam int unsigned OFS_DOFF     = 12;
  localparam int unsigned OFS_FLAGS    = 13;

  // Frame verdict codes
  typedef enum logic [3:0] {
    V_OK        = 4'd0,
    V_SHORT     = 4'd1,
    V_ETHERTYPE = 4'd2,
    V_VERSION   = 4'd3,
    V_PROTOCOL  = 4'd4,
    V_SOURCE    = 4'd5,
    V_PORT      = 4'd6,
    V_RESET     = 4'd7,
    V_FLAGS     = 4'd8,
    V_EMPTY     = 4'd9,
    V_TRUNC     = 4'd10
  } verdict_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LOCAL_PORT  = 2'd0,
    REG_REMOTE_IP   = 2'd1,
    REG_WAIT_MODE   = 2'd2,
    REG_EXP_FLAGS   = 2'd3
  } reg_idx_e;

  // Segment mode of the current frame
  typedef enum logic [2:0] {
    MODE_HDR  = 3'b001,
    MODE_DATA = 3'b010,
    MODE_WAIT = 3'b100
  } seg_mode_e;

  // Result item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  verdict;
    logic        reset_seen;
    logic [31:0] ack_number;
    logic [15:0] payload_length;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

endpackage

`default_nettype wire

// ----- design/tcprf_if.sv -----
// Interfaces: frame input, result output and configuration write channels.
`default_nettype none

interface tcprf_in_if
  import tcprf_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcprf_out_if
  import tcprf_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcprf_cfg_if
  import tcprf_pkg::*;
  ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/tcp_receive_frame_filter_unit.sv -----
// Top level: Ethernet/IPv4/TCP receive filter with payload streaming and verdicts.
// Queueing: a result enters the output queue at the edge that accepts its byte.
//   Throughput: one frame byte per cycle while the queue has room for two results;
//   a byte yields at most two results (payload byte and verdict), and the four-entry
//   result queue sets the rate only when the sink stalls or results outnumber bytes.
// Reset: all registers, the ack register and the queue pointers and count clear; no clearing pass.
`default_nettype none

module tcp_receive_frame_filter_unit
  import tcprf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tcprf_in_if.sink    in_i,
  tcprf_cfg_if.sink   cfg_i,
  tcprf_out_if.source out_o
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  // Configuration registers
  logic [15:0] local_port_q;
  logic [31:0] remote_ip_q;
  logic        wait_mode_q;
  logic [7:0]  exp_flags_q;

  // Frame state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      scratch_q, scratch_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [3:0]       thw_q, thw_d;
  logic [15:0]      tot_q, tot_d;
  logic [31:0]      seq_q, seq_d;
  verdict_e         verdict_q, verdict_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      len_q, len_d;
  seg_mode_e        mode_q, mode_d;
  logic [31:0]      ack_q, ack_d;

  // Result queue
  out_item_t        res_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic        emit;
  verdict_e    final_v;
  logic [15:0] out_len;
  logic [POS_W-1:0] hdr_end;
  logic [POS_W-1:0] ofs;
  logic [6:0]  hdr_sum;
  out_item_t   pay_item, ver_item;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign b        = in_i.data.frame_byte;
  assign hdr_end  = POS_W'(POS_IP_START) + POS_W'({ihl_q, 2'b00});
  assign ofs      = pos_q - hdr_end;
  assign hdr_sum  = 7'({ihl_q, 2'b00}) + 7'({thw_q, 2'b00});

  // Take configuration writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_port_q <= '0;
      remote_ip_q  <= '0;
      wait_mode_q  <= 1'b0;
      exp_flags_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.data.index))
        REG_LOCAL_PORT: local_port_q <= cfg_i.data.data[15:0];
        REG_REMOTE_IP:  remote_ip_q  <= cfg_i.data.data;
        REG_WAIT_MODE:  wait_mode_q  <= cfg_i.data.data[0];
        REG_EXP_FLAGS:  exp_flags_q  <= cfg_i.data.data[7:0];
        default:        local_port_q <= local_port_q;
      endcase
    end
  end

  // Parse one frame byte and form its results
  always_comb begin
    pos_d     = pos_q;
    scratch_d = scratch_q;
    ihl_d     = ihl_q;
    thw_d     = thw_q;
    tot_d     = tot_q;
    seq_d     = seq_q;
    verdict_d = verdict_q;
    rem_d     = rem_q;
    len_d     = len_q;
    mode_d    = mode_q;
    ack_d     = ack_q;
    emit      = 1'b0;
    final_v   = V_OK;
    out_len   = '0;

    if (in_fire) begin
      if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
        pos_d = pos_q + POS_W'(1);
        if (verdict_q == V_OK) begin
          if (pos_q == POS_W'(POS_TYPE_HI)) begin
            scratch_d = {24'h0, b};
          end else if (pos_q == POS_W'(POS_TYPE_LO)) begin
            if ({scratch_q[7:0], b} != ETHERTYPE_IPV4) verdict_d = V_ETHERTYPE;
          end else if (pos_q == POS_W'(POS_VER_IHL)) begin
            if ((b & VERSION_MASK) != VERSION_IPV4) begin
              verdict_d = V_VERSION;
            end else begin
              ihl_d = 4'(b & IHL_MASK);
              if (4'(b & IHL_MASK) < MIN_HDR_WORDS) verdict_d = V_VERSION;
            end
          end else if (pos_q == POS_W'(POS_TOT_HI)) begin
            tot_d = {b, 8'h00};
          end else if (pos_q == POS_W'(POS_TOT_LO)) begin
            tot_d = {tot_q[15:8], b};
          end else if (pos_q == POS_W'(POS_PROTO)) begin
            if (b != PROTO_TCP) verdict_d = V_PROTOCOL;
          end else if (pos_q >= POS_W'(POS_SRC_0) && pos_q <= POS_W'(POS_SRC_3)) begin
            scratch_d = {scratch_q[23:0], b};
            if (pos_q == POS_W'(POS_SRC_3) && remote_ip_q != '0 &&
                scratch_d != remote_ip_q) begin
              verdict_d = V_SOURCE;
            end
          end else if (pos_q >= POS_W'(POS_TCP_MIN) && pos_q >= hdr_end) begin
            if (ofs == POS_W'(OFS_DPORT_HI)) begin
              scratch_d = {24'h0, b};
            end else if (ofs == POS_W'(OFS_DPORT_LO)) begin
              if ({scratch_q[7:0], b} != local_port_q) verdict_d = V_PORT;
            end else if (ofs >= POS_W'(OFS_SEQ_0) && ofs <= POS_W'(OFS_SEQ_3)) begin
              seq_d = {seq_q[23:0], b};
            end else if (ofs == POS_W'(OFS_DOFF)) begin
              thw_d = b[7:4];
            end else if (ofs == POS_W'(OFS_FLAGS)) begin
              // Check flags and fix the segment mode
              if ((b & FLAG_RST) != '0) begin
                verdict_d = V_RESET;
              end else if (wait_mode_q) begin
                if ((b & exp_flags_q) != exp_flags_q) verdict_d = V_FLAGS;
                else mode_d = MODE_WAIT;
              end else if (thw_q < MIN_HDR_WORDS) begin
                verdict_d = V_EMPTY;
              end else if (tot_q <= 16'(hdr_sum)) begin
                verdict_d = V_EMPTY;
              end else begin
                rem_d  = tot_q - 16'(hdr_sum);
                len_d  = tot_q - 16'(hdr_sum);
                mode_d = MODE_DATA;
              end
            end else if (mode_q == MODE_DATA && ofs >= POS_W'({thw_q, 2'b00}) &&
                         rem_q != '0) begin
              rem_d = rem_q - 16'd1;
              emit  = 1'b1;
            end
          end
        end
      end

      // Close the frame on its last byte
      if (in_i.data.frame_last) begin
        if (pos_d < POS_W'(MIN_FRAME))                    final_v = V_SHORT;
        else if (verdict_d != V_OK)                       final_v = verdict_d;
        else if (mode_d == MODE_HDR)                      final_v = V_TRUNC;
        else if (mode_d == MODE_DATA && rem_d != '0)      final_v = V_TRUNC;
        else                                              final_v = V_OK;

        if (final_v == V_OK) begin
          if (mode_d == MODE_DATA) begin
            ack_d   = seq_d + {16'h0, len_d};
            out_len = len_d;
          end else begin
            ack_d = seq_d + 32'd1;
          end
        end

        pos_d     = '0;
        scratch_d = '0;
        ihl_d     = '0;
        thw_d     = '0;
        tot_d     = '0;
        seq_d     = '0;
        verdict_d = V_OK;
        rem_d     = '0;
        len_d     = '0;
        mode_d    = MODE_HDR;
      end
    end
  end

  always_comb begin
    pay_item                = '0;
    pay_item.item_kind      = KIND_PAYLOAD;
    pay_item.payload_byte   = b;
    pay_item.ack_number     = ack_q;

    ver_item                = '0;
    ver_item.item_kind      = KIND_VERDICT;
    ver_item.verdict        = final_v;
    ver_item.reset_seen     = (final_v == V_RESET);
    ver_item.ack_number     = ack_d;
    ver_item.payload_length = out_len;
    ver_item.run_last       = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      scratch_q <= '0;
      ihl_q     <= '0;
      thw_q     <= '0;
      tot_q     <= '0;
      seq_q     <= '0;
      verdict_q <= V_OK;
      rem_q     <= '0;
      len_q     <= '0;
      mode_q    <= MODE_HDR;
      ack_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      scratch_q <= scratch_d;
      ihl_q     <= ihl_d;
      thw_q     <= thw_d;
      tot_q     <= tot_d;
      seq_q     <= seq_d;
      verdict_q <= verdict_d;
      rem_q     <= rem_d;
      len_q     <= len_d;
      mode_q    <= mode_d;
      ack_q     <= ack_d;
    end
  end

  // Result queue: push up to two items, pop one per output transaction
  logic             push_ver;
  logic [1:0]       n_push;

  assign push_ver = in_fire && in_i.data.frame_last;
  assign n_push   = {1'b0, emit} + {1'b0, push_ver};

  assign in_i.ready  = (cnt_q <= CNT_W'(RES_DEPTH - 2));
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = res_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q[wr_ptr_q] <= pay_item;
      if (push_ver) res_q[wr_ptr_q + PTR_W'(1)] <= ver_item;
    end else if (push_ver) begin
      res_q[wr_ptr_q] <= ver_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      if (out_fire) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(out_fire);
    end
  end

endmodule

`default_nettype wire
